>>> sv/metaball_cell_classifier_macros.svh
// ---------------------------------------------------------------------------
// Metaball cell classifier assertion macros
// Concurrent checks on clk, disabled while rst_n is low; empty under SYNTH.
// ---------------------------------------------------------------------------
`ifndef METABALL_CELL_CLASSIFIER_MACROS_SVH
`define METABALL_CELL_CLASSIFIER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define MBCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbcc assertion failed");
// next-cycle implication
`define MBCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbcc assertion failed");
`else
`define MBCC_ASSERT_NOW(lbl, ante, cons)
`define MBCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/mbcc_pkg.sv
// ---------------------------------------------------------------------------
// mbcc_pkg
// Shared types, constants and the segment lookup of the metaball classifier.
// ---------------------------------------------------------------------------
package mbcc_pkg;

  localparam int NUM_BALLS   = 8;
  localparam int BALL_W      = (NUM_BALLS > 1) ? $clog2(NUM_BALLS) : 1;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam logic [5:0] CELL_SIZE_RST = 6'd10;
  localparam logic [7:0] THR_NUM_RST   = 8'd7;
  localparam logic [7:0] THR_DEN_RST   = 8'd10;

  localparam logic [1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [1:0] REG_THR_NUM   = 2'd1;
  localparam logic [1:0] REG_THR_DEN   = 2'd2;

  localparam logic [1:0] EDGE_WEST  = 2'd0;
  localparam logic [1:0] EDGE_LOWER = 2'd1;
  localparam logic [1:0] EDGE_EAST  = 2'd2;
  localparam logic [1:0] EDGE_UPPER = 2'd3;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t     op;
    logic [2:0]  ball_index;
    logic [9:0]  ball_x;
    logic [9:0]  ball_y;
    logic [7:0]  ball_rad;
    logic [9:0]  cell_x;
    logic [9:0]  cell_y;
  } cmd_t;

  typedef struct packed {
    logic [5:0] cell_size;
    logic [7:0] threshold_num;
    logic [7:0] threshold_den;
  } cfg_t;

  // first member is the most significant: case_code lands in the low bits
  typedef struct packed {
    logic [1:0] second_end_edge;
    logic [1:0] second_start_edge;
    logic [1:0] first_end_edge;
    logic [1:0] first_start_edge;
    logic [1:0] segment_count;
    logic [3:0] case_code;
  } out_item_t;

  function automatic out_item_t seg_lookup(input logic [3:0] code);
    out_item_t o;
    o           = '0;
    o.case_code = code;
    case (code) inside
      4'd1, 4'd14: begin
        o.segment_count    = 2'd1;
        o.first_start_edge = EDGE_WEST;
        o.first_end_edge   = EDGE_LOWER;
      end
      4'd2, 4'd13: begin
        o.segment_count    = 2'd1;
        o.first_start_edge = EDGE_EAST;
        o.first_end_edge   = EDGE_LOWER;
      end
      4'd3, 4'd12: begin
        o.segment_count    = 2'd1;
        o.first_start_edge = EDGE_WEST;
        o.first_end_edge   = EDGE_EAST;
      end
      4'd4, 4'd11: begin
        o.segment_count    = 2'd1;
        o.first_start_edge = EDGE_UPPER;
        o.first_end_edge   = EDGE_EAST;
      end
      4'd5: begin
        o.segment_count     = 2'd2;
        o.first_start_edge  = EDGE_EAST;
        o.first_end_edge    = EDGE_LOWER;
        o.second_start_edge = EDGE_WEST;
        o.second_end_edge   = EDGE_UPPER;
      end
      4'd6, 4'd9: begin
        o.segment_count    = 2'd1;
        o.first_start_edge = EDGE_UPPER;
        o.first_end_edge   = EDGE_LOWER;
      end
      4'd7, 4'd8: begin
        o.segment_count    = 2'd1;
        o.first_start_edge = EDGE_WEST;
        o.first_end_edge   = EDGE_UPPER;
      end
      4'd10: begin
        o.segment_count     = 2'd2;
        o.first_start_edge  = EDGE_WEST;
        o.first_end_edge    = EDGE_LOWER;
        o.second_start_edge = EDGE_UPPER;
        o.second_end_edge   = EDGE_EAST;
      end
      default: begin
        o.segment_count = 2'd0;
      end
    endcase
    return o;
  endfunction

endpackage

>>> sv/mbcc_front.sv
// ---------------------------------------------------------------------------
// mbcc_front
// Unpacks input items into commands and drops loads beyond the ball table.
// ---------------------------------------------------------------------------
module mbcc_front (
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mbcc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,
  output logic                                push_valid,
  input  logic                                push_ready,
  output mbcc_pkg::cmd_t                      push_cmd
);
  import mbcc_pkg::*;

  logic keep;

  always_comb begin
    push_cmd.op         = opcode_t'(in_tuser);
    push_cmd.ball_index = in_tdata[2:0];
    push_cmd.ball_x     = in_tdata[12:3];
    push_cmd.ball_y     = in_tdata[22:13];
    push_cmd.ball_rad   = in_tdata[30:23];
    push_cmd.cell_x     = in_tdata[40:31];
    push_cmd.cell_y     = in_tdata[50:41];
  end

  // a load past the table is taken and dropped
  assign keep       = (push_cmd.op == OP_CLASSIFY) ||
                      (32'(push_cmd.ball_index) < NUM_BALLS);
  assign in_tready  = push_ready;
  assign push_valid = in_tvalid && keep;

endmodule

>>> sv/mbcc_cmd_fifo.sv
// ---------------------------------------------------------------------------
// mbcc_cmd_fifo
// Short command queue between the front and back parts.
// ---------------------------------------------------------------------------
module mbcc_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  mbcc_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mbcc_pkg::cmd_t  pop_cmd
);
  import mbcc_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        mem_r[wp_r] <= push_cmd;
        wp_r        <= (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> sv/mbcc_back.sv
// ---------------------------------------------------------------------------
// mbcc_back
// Ball table and corner tester: one ball/corner distance test per cycle
// through a three-stage multiply pipeline, then segment lookup and output.
// ---------------------------------------------------------------------------
`include "metaball_cell_classifier_macros.svh"

module mbcc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  mbcc_pkg::cmd_t                    pop_cmd,
  input  mbcc_pkg::cfg_t                    cfg,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mbcc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import mbcc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  localparam logic [1:0]        CORNER_TL = 2'd0;
  localparam logic [1:0]        CORNER_TR = 2'd1;
  localparam logic [1:0]        CORNER_BR = 2'd2;
  localparam logic [1:0]        CORNER_BL = 2'd3;
  localparam logic [BALL_W-1:0] BALL_LAST = BALL_W'(NUM_BALLS - 1);

  state_t            state_r;
  logic [BALL_W-1:0] ball_r;
  logic [1:0]        corner_r;
  logic [9:0]        x0_r;
  logic [9:0]        y0_r;
  logic [3:0]        acc_r;

  logic [9:0]        pos_x_r [NUM_BALLS];
  logic [9:0]        pos_y_r [NUM_BALLS];
  logic [7:0]        rad_r   [NUM_BALLS];

  logic              s1_valid_r, s1_last_r;
  logic [1:0]        s1_corner_r;
  logic [10:0]       s1_dx_r, s1_dy_r;
  logic [7:0]        s1_r_r;

  logic              s2_valid_r, s2_last_r, s2_rnz_r;
  logic [1:0]        s2_corner_r;
  logic [21:0]       s2_dx2_r, s2_dy2_r;
  logic [15:0]       s2_r2_r;

  logic              s3_valid_r, s3_last_r, s3_rnz_r;
  logic [1:0]        s3_corner_r;
  logic [23:0]       s3_lhs_r;
  logic [30:0]       s3_rhs_r;

  out_item_t         out_r;
  logic              out_valid_r;
  out_item_t         pend_r;
  logic              pend_valid_r;

  logic [10:0]       x1, y1, px, py, bx, by;
  logic [10:0]       dx, dy;
  logic [22:0]       d2;
  logic              issue_last;
  logic              hit;
  logic [3:0]        acc_nxt;
  logic              fin;
  out_item_t         res;
  logic              out_take;
  logic              pop_fire;

  assign x1 = {1'b0, x0_r} + {5'd0, cfg.cell_size};
  assign y1 = {1'b0, y0_r} + {5'd0, cfg.cell_size};
  assign px = (corner_r == CORNER_TR || corner_r == CORNER_BR) ? x1 : {1'b0, x0_r};
  assign py = (corner_r == CORNER_BR || corner_r == CORNER_BL) ? y1 : {1'b0, y0_r};
  assign bx = {1'b0, pos_x_r[ball_r]};
  assign by = {1'b0, pos_y_r[ball_r]};
  assign dx = (px >= bx) ? px - bx : bx - px;
  assign dy = (py >= by) ? py - by : by - py;
  assign d2 = {1'b0, s2_dx2_r} + {1'b0, s2_dy2_r};

  assign issue_last = (corner_r == CORNER_BL) && (ball_r == BALL_LAST);
  assign hit        = s3_valid_r && s3_rnz_r && ({7'd0, s3_lhs_r} >= s3_rhs_r);
  assign acc_nxt    = acc_r | (hit ? (4'b0001 << s3_corner_r) : 4'b0000);
  assign fin        = s3_valid_r && s3_last_r;
  assign res        = seg_lookup({acc_nxt[CORNER_TL], acc_nxt[CORNER_TR],
                                  acc_nxt[CORNER_BR], acc_nxt[CORNER_BL]});
  assign out_take   = out_valid_r && out_tready;

  // a classify waits until the overflow slot is free
  assign pop_ready  = (state_r == ST_IDLE) &&
                      ((pop_cmd.op == OP_LOAD) || !pend_valid_r);
  assign pop_fire   = pop_valid && pop_ready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(out_item_t)){1'b0}}, out_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ball_r       <= '0;
      corner_r     <= CORNER_TL;
      acc_r        <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BALLS; i++) begin
        rad_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (pop_fire) begin
            if (pop_cmd.op == OP_LOAD) begin
              pos_x_r[BALL_W'(pop_cmd.ball_index)] <= pop_cmd.ball_x;
              pos_y_r[BALL_W'(pop_cmd.ball_index)] <= pop_cmd.ball_y;
              rad_r[BALL_W'(pop_cmd.ball_index)]   <= pop_cmd.ball_rad;
            end else begin
              x0_r     <= pop_cmd.cell_x;
              y0_r     <= pop_cmd.cell_y;
              ball_r   <= '0;
              corner_r <= CORNER_TL;
              state_r  <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (ball_r == BALL_LAST) begin
            ball_r   <= '0;
            corner_r <= corner_r + 2'd1;
          end else begin
            ball_r <= ball_r + 1'b1;
          end
          if (issue_last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (fin) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // test pipeline
      s1_valid_r  <= (state_r == ST_RUN);
      s1_last_r   <= issue_last;
      s1_corner_r <= corner_r;
      s1_dx_r     <= dx;
      s1_dy_r     <= dy;
      s1_r_r      <= rad_r[ball_r];

      s2_valid_r  <= s1_valid_r;
      s2_last_r   <= s1_last_r;
      s2_corner_r <= s1_corner_r;
      s2_rnz_r    <= (s1_r_r != 8'd0);
      s2_dx2_r    <= {11'd0, s1_dx_r} * {11'd0, s1_dx_r};
      s2_dy2_r    <= {11'd0, s1_dy_r} * {11'd0, s1_dy_r};
      s2_r2_r     <= {8'd0, s1_r_r} * {8'd0, s1_r_r};

      s3_valid_r  <= s2_valid_r;
      s3_last_r   <= s2_last_r;
      s3_corner_r <= s2_corner_r;
      s3_rnz_r    <= s2_rnz_r;
      s3_lhs_r    <= {8'd0, s2_r2_r} * {16'd0, cfg.threshold_den};
      s3_rhs_r    <= {23'd0, cfg.threshold_num} * {8'd0, d2};

      // clear the corner bits as a new cell starts
      if (pop_fire && (pop_cmd.op == OP_CLASSIFY)) begin
        acc_r <= '0;
      end else begin
        acc_r <= acc_nxt;
      end

      // output register with one overflow slot
      if (fin) begin
        if (!out_valid_r || out_take) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          pend_r       <= res;
          pend_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        if (pend_valid_r) begin
          out_r        <= pend_r;
          pend_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  `MBCC_ASSERT_NOW(a_fin_slot_free, fin, !pend_valid_r)
  `MBCC_ASSERT_NOW(a_pend_behind_out, pend_valid_r, out_valid_r)
  `MBCC_ASSERT_NOW(a_last_in_drain, fin, state_r == ST_DRAIN)
  `MBCC_ASSERT_NEXT(a_start_clean, pop_fire && (pop_cmd.op == OP_CLASSIFY),
                    (state_r == ST_RUN) && (acc_r == 4'd0))

endmodule

>>> sv/metaball_cell_classifier.sv
// ---------------------------------------------------------------------------
// metaball_cell_classifier
// Marching-squares case classifier over a table of metaballs.
// ---------------------------------------------------------------------------
// Flow: a classify item leaves the command queue, then each corner is
//   tested against each ball in turn on the one shared multiply pipeline,
//   which then drains its 3 stages; the next classify is taken only once
//   its last test has left the pipeline. Load items go one per cycle while
//   the back part is idle and are written to the ball table as they pop.
// Reset (rst_n low, synchronous): queue and outputs empty, all balls off,
//   cell_size 10, threshold 7/10; no clearing pass.
module metaball_cell_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // ball_index, ball_x, ball_y, ball_rad, cell_x, cell_y
  input  logic [mbcc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // opcode
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // case_code, segment_count, first_start_edge, first_end_edge,
  // second_start_edge, second_end_edge
  output logic [mbcc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mbcc_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [mbcc_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [mbcc_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import mbcc_pkg::*;

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  cmd_t       push_cmd, pop_cmd;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_size     <= CELL_SIZE_RST;
      cfg_r.threshold_num <= THR_NUM_RST;
      cfg_r.threshold_den <= THR_DEN_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CELL_SIZE: cfg_r.cell_size     <= cfg_pwdata[5:0];
        REG_THR_NUM:   cfg_r.threshold_num <= cfg_pwdata[7:0];
        REG_THR_DEN:   cfg_r.threshold_den <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CELL_SIZE: cfg_prdata = {26'd0, cfg_r.cell_size};
      REG_THR_NUM:   cfg_prdata = {24'd0, cfg_r.threshold_num};
      REG_THR_DEN:   cfg_prdata = {24'd0, cfg_r.threshold_den};
      default:       cfg_prdata = '0;
    endcase
  end

  mbcc_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  mbcc_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  mbcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .cfg        (cfg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// Metaball cell classifier testbench
// Loads balls and classifies cells over several register settings, predicts
// each case code and its contour segments, and checks every result item.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mbcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 500;
  localparam int HOLD_AFTER     = 120;
  localparam int RAND_PER_PHASE = 190;
  localparam int NUM_PHASES     = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  // predicted block state
  logic [9:0] tbl_x [NUM_BALLS];
  logic [9:0] tbl_y [NUM_BALLS];
  logic [7:0] tbl_r [NUM_BALLS];
  logic [5:0] cur_size;
  logic [7:0] cur_num;
  logic [7:0] cur_den;

  cmd_t      cmds_to_send [$];
  out_item_t cases_due [$];
  cmd_t      drv_cmd;

  // ball positions as issued, used to aim classify items near the balls
  logic [9:0] gen_x [NUM_BALLS];
  logic [9:0] gen_y [NUM_BALLS];

  int  mismatches = 0;
  int  accepted_cnt;
  int  gap_left;
  int  stall_left;
  int  hold_left;
  bit  hold_done;
  bit  quiet_tail = 1'b0;
  int  idle_cycles;

  metaball_cell_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // tdata fields from bit 0 up: ball_index, ball_x, ball_y, ball_rad, cell_x, cell_y
  function automatic logic [IN_TDATA_W-1:0] pack_cmd(input cmd_t c);
    logic [IN_TDATA_W-1:0] d;
    d        = '0;
    d[2:0]   = c.ball_index;
    d[12:3]  = c.ball_x;
    d[22:13] = c.ball_y;
    d[30:23] = c.ball_rad;
    d[40:31] = c.cell_x;
    d[50:41] = c.cell_y;
    return d;
  endfunction

  function automatic cmd_t unpack_cmd(input logic [IN_TDATA_W-1:0] d, input logic op);
    cmd_t c;
    c.op         = opcode_t'(op);
    c.ball_index = d[2:0];
    c.ball_x     = d[12:3];
    c.ball_y     = d[22:13];
    c.ball_rad   = d[30:23];
    c.cell_x     = d[40:31];
    c.cell_y     = d[50:41];
    return c;
  endfunction

  function automatic bit corner_in_field(input logic [10:0] px, input logic [10:0] py);
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] reach;
    logic [63:0] spread;
    bit          hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_BALLS; i++) begin
      if (tbl_r[i] != 0) begin
        dx     = (px >= tbl_x[i]) ? px - tbl_x[i] : tbl_x[i] - px;
        dy     = (py >= tbl_y[i]) ? py - tbl_y[i] : tbl_y[i] - py;
        reach  = 64'(tbl_r[i]) * 64'(tbl_r[i]) * 64'(cur_den);
        spread = 64'(cur_num) * (dx * dx + dy * dy);
        if (reach >= spread) hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // contour segments between edge midpoints for one corner pattern
  function automatic out_item_t contour_of(input logic [3:0] code);
    out_item_t o;
    o           = '0;
    o.case_code = code;
    case (code)
      4'd1, 4'd14: begin
        o.segment_count = 2'd1;
        {o.first_start_edge, o.first_end_edge} = {EDGE_WEST, EDGE_LOWER};
      end
      4'd2, 4'd13: begin
        o.segment_count = 2'd1;
        {o.first_start_edge, o.first_end_edge} = {EDGE_EAST, EDGE_LOWER};
      end
      4'd3, 4'd12: begin
        o.segment_count = 2'd1;
        {o.first_start_edge, o.first_end_edge} = {EDGE_WEST, EDGE_EAST};
      end
      4'd4, 4'd11: begin
        o.segment_count = 2'd1;
        {o.first_start_edge, o.first_end_edge} = {EDGE_UPPER, EDGE_EAST};
      end
      4'd6, 4'd9: begin
        o.segment_count = 2'd1;
        {o.first_start_edge, o.first_end_edge} = {EDGE_UPPER, EDGE_LOWER};
      end
      4'd7, 4'd8: begin
        o.segment_count = 2'd1;
        {o.first_start_edge, o.first_end_edge} = {EDGE_WEST, EDGE_UPPER};
      end
      4'd5: begin
        // saddle with TR and BL set
        o.segment_count = 2'd2;
        {o.first_start_edge, o.first_end_edge}   = {EDGE_EAST, EDGE_LOWER};
        {o.second_start_edge, o.second_end_edge} = {EDGE_WEST, EDGE_UPPER};
      end
      4'd10: begin
        // saddle with TL and BR set
        o.segment_count = 2'd2;
        {o.first_start_edge, o.first_end_edge}   = {EDGE_WEST, EDGE_LOWER};
        {o.second_start_edge, o.second_end_edge} = {EDGE_UPPER, EDGE_EAST};
      end
      default: o.segment_count = 2'd0;
    endcase
    return o;
  endfunction

  task automatic absorb_item(input cmd_t c);
    logic [10:0] x0;
    logic [10:0] y0;
    logic [10:0] x1;
    logic [10:0] y1;
    logic [3:0]  code;
    if (c.op == OP_LOAD) begin
      tbl_x[c.ball_index] = c.ball_x;
      tbl_y[c.ball_index] = c.ball_y;
      tbl_r[c.ball_index] = c.ball_rad;
    end else begin
      x0   = {1'b0, c.cell_x};
      y0   = {1'b0, c.cell_y};
      x1   = x0 + cur_size;
      y1   = y0 + cur_size;
      code = {corner_in_field(x0, y0), corner_in_field(x1, y0),
              corner_in_field(x1, y1), corner_in_field(x0, y1)};
      cases_due.push_back(contour_of(code));
    end
  endtask

  // driver: advance to the next item once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left != 0) begin
        in_tvalid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (cmds_to_send.size() != 0) begin
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
          in_tvalid <= 1'b0;
          gap_left  <= $urandom_range(0, 2);
        end else begin
          drv_cmd = cmds_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= pack_cmd(drv_cmd);
          in_tuser  <= drv_cmd.op;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: short random stalls plus one long hold to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
      out_tready <= 1'b0;
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: predict on each accepted input item, check each result item
  always @(posedge clk) begin : monitor_proc
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      accepted_cnt <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_item(unpack_cmd(in_tdata, in_tuser));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_tvalid && out_tready) begin
        got = out_item_t'(out_tdata[$bits(out_item_t)-1:0]);
        if (cases_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result item case %0d", $time, got.case_code);
        end else begin
          want = cases_due.pop_front();
          if (got.case_code !== want.case_code ||
              got.segment_count !== want.segment_count ||
              got.first_start_edge !== want.first_start_edge ||
              got.first_end_edge !== want.first_end_edge ||
              got.second_start_edge !== want.second_start_edge ||
              got.second_end_edge !== want.second_end_edge) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: exp %0d/%0d %0d-%0d %0d-%0d, got %0d/%0d %0d-%0d %0d-%0d",
                       $time, want.case_code, want.segment_count, want.first_start_edge,
                       want.first_end_edge, want.second_start_edge, want.second_end_edge,
                       got.case_code, got.segment_count, got.first_start_edge,
                       got.first_end_edge, got.second_start_edge, got.second_end_edge);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input int value, input int width,
                           input bit dirty_upper);
    logic [CFG_DW-1:0] wdata;
    wdata = CFG_DW'(value);
    if (dirty_upper) wdata = wdata | ($urandom() << width);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_CELL_SIZE: cur_size = wdata[5:0];
      REG_THR_NUM:   cur_num  = wdata[7:0];
      REG_THR_DEN:   cur_den  = wdata[7:0];
      default: ;
    endcase
  endtask

  task automatic send_load(input int idx, input int x, input int y, input int rad);
    cmd_t c;
    c            = '0;
    c.op         = OP_LOAD;
    c.ball_index = 3'(idx);
    c.ball_x     = 10'(x);
    c.ball_y     = 10'(y);
    c.ball_rad   = 8'(rad);
    gen_x[idx]   = c.ball_x;
    gen_y[idx]   = c.ball_y;
    cmds_to_send.push_back(c);
  endtask

  task automatic send_classify(input int x, input int y);
    cmd_t c;
    // unused fields carry noise; the block must ignore them
    c            = cmd_t'({$urandom(), $urandom()});
    c.op         = OP_CLASSIFY;
    c.cell_x     = 10'(x);
    c.cell_y     = 10'(y);
    cmds_to_send.push_back(c);
  endtask

  function automatic int clamp_px(input int v);
    return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
  endfunction

  task automatic send_random(input int size);
    int j;
    int span;
    int rad;
    span = size + 8;
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 7))
        0:       rad = 0;
        1:       rad = $urandom_range(0, 255);
        default: rad = $urandom_range(1, (2 * size + 10 > 255) ? 255 : 2 * size + 10);
      endcase
      send_load($urandom_range(0, NUM_BALLS - 1), $urandom_range(0, 1023),
                $urandom_range(0, 1023), rad);
    end else if ($urandom_range(0, 4) == 0) begin
      send_classify($urandom_range(0, 1023), $urandom_range(0, 1023));
    end else begin
      // aim the cell so its corners straddle a ball's edge
      j = $urandom_range(0, NUM_BALLS - 1);
      send_classify(clamp_px(int'(gen_x[j]) + $urandom_range(0, 2 * span) - span),
                    clamp_px(int'(gen_y[j]) + $urandom_range(0, 2 * span) - span));
    end
  endtask

  // hold until every item is taken and every result is back, then let loads settle
  task automatic drain;
    @(negedge clk);
    while (cmds_to_send.size() != 0 || in_tvalid || cases_due.size() != 0)
      @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  initial begin : stimulus
    int sz  [NUM_PHASES];
    int num [NUM_PHASES];
    int den [NUM_PHASES];
    bit dirty;
    for (int i = 0; i < NUM_BALLS; i++) begin
      tbl_x[i] = '0;
      tbl_y[i] = '0;
      tbl_r[i] = '0;
      gen_x[i] = '0;
      gen_y[i] = '0;
    end
    cur_size = CELL_SIZE_RST;
    cur_num  = THR_NUM_RST;
    cur_den  = THR_DEN_RST;

    // phase 0 keeps reset values; the last phase restores them with no idling
    sz  = '{10, 1,   63, 0,  10, 10, 0, 10};
    num = '{7,  1,   255, 7, 0,  7,  0, 7};
    den = '{10, 255, 1,  10, 10, 0,  0, 10};
    sz[6]  = $urandom_range(1, 63);
    num[6] = $urandom_range(1, 255);
    den[6] = $urandom_range(1, 255);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, zero radius on the corner, ball exactly on a corner
    send_classify(0, 0);
    send_load(0, 0, 0, 0);
    send_classify(0, 0);
    send_load(1, 20, 20, 1);
    send_classify(20, 20);
    // corners beyond the pixel range
    send_load(7, 1023, 1023, 255);
    send_classify(1023, 1023);
    // both saddles
    send_load(3, 100, 100, 3);
    send_load(4, 110, 110, 3);
    send_classify(100, 100);
    send_load(5, 210, 200, 3);
    send_load(6, 200, 210, 3);
    send_classify(200, 200);
    // single corners
    send_classify(90, 100);
    send_classify(100, 90);
    send_classify(90, 90);
    send_load(2, 1023, 0, 255);
    send_classify(1023, 0);
    send_load(0, 0, 1023, 255);
    send_classify(0, 1023);
    send_classify(0, 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        drain();
        dirty = (p == 6);
        reg_write(REG_CELL_SIZE, sz[p], 6, dirty);
        reg_write(REG_THR_NUM, num[p], 8, dirty);
        reg_write(REG_THR_DEN, den[p], 8, dirty);
        @(negedge clk);
      end
      if (p == NUM_PHASES - 1) quiet_tail = 1'b1;
      for (int k = 0; k < RAND_PER_PHASE; k++) send_random(sz[p]);
    end
    drain();

    if (mismatches == 0 && cases_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
